// ----- design/u8lru_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8lru_pkg
// Shared types and constants of the UTF-8 decoder with LRU glyph slot cache.
// ----------------------------------------------------------------------------
package u8lru_pkg;

	// Cache geometry
	localparam int SlotCountDefault = 105;
	localparam int SylWidth         = 14;
	localparam int AgeWidth         = 32;
	localparam int EntryWidth       = SylWidth + AgeWidth;

	// Code point ranges and display codes
	localparam logic [20:0] HangulFirst = 21'h00AC00;
	localparam logic [20:0] HangulLast  = 21'h00D7A3;
	localparam logic [7:0]  SlotBase    = 8'd151;
	localparam logic [7:0]  CharUnknown = 8'd63;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	// Decoded character
	typedef struct packed {
		logic        at_end;
		logic [2:0]  used;
		logic [20:0] point;
	} dec_t;

	// One cache entry as kept in memory
	typedef struct packed {
		logic [SylWidth-1:0] syl;
		logic [AgeWidth-1:0] age;
	} entry_t;

endpackage
`default_nettype wire

// ----- design/u8lru_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8lru_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module u8lru_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule
`default_nettype wire

// ----- design/utf8_to_char_code_lru_glyph_slots.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_to_char_code_lru_glyph_slots
// UTF-8 decoder that maps Hangul syllables to font slots through an LRU cache.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) takes a four-byte text window. Output
//   channel (out_valid / out_stall) returns one result per request: end flag,
//   bytes consumed, code point, display code and an optional glyph load.
//   One request is processed at a time. A non-Hangul request passes through
//   ST_FINISH into the output register once that register is free. A Hangul
//   request scans the cache RAM one entry per cycle over its read port, up to
//   the first hit or until all filled slots are read (a miss), then writes the
//   hit or victim slot and goes on to ST_FINISH.
//   After the result enters the output register the sequencer returns to idle
//   and accepts the next request.
//   This holds even while that result still waits in the output register;
//   the new result then holds until that register is free.
//   Reset empties the cache (fill count zero) and sets the age stamp to one.
//   Slots fill in order, so only a fill count tracks validity and no clearing
//   pass is needed. A stalled receiver freezes the output register, and
//   in_stall stays high until the waiting result moves into it.
// ----------------------------------------------------------------------------
module utf8_to_char_code_lru_glyph_slots #(
	parameter int SLOT_COUNT = u8lru_pkg::SlotCountDefault
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  byte_first,
	input  wire logic [7:0]  byte_second,
	input  wire logic [7:0]  byte_third,
	input  wire logic [7:0]  byte_fourth,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             at_end,
	output logic [2:0]       bytes_used,
	output logic [20:0]      decoded_point,
	output logic [7:0]       char_code,
	output logic             load_glyph,
	output logic [13:0]      font_index
);

	import u8lru_pkg::*;

	localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CW = $clog2(SLOT_COUNT + 1);
	localparam logic [CW-1:0] FullCount = CW'(SLOT_COUNT);

	// Control state
	state_t              state_q, state_d;
	logic [CW-1:0]       fill_q;
	logic [AgeWidth-1:0] age_q;
	logic [CW-1:0]       idx_q;
	logic                pend_s1;
	logic [AW-1:0]       idx_s1;
	logic                out_valid_q;

	// Request and result registers
	logic                at_end_q;
	logic [2:0]          used_q;
	logic [20:0]         point_q;
	logic [SylWidth-1:0] syl_q;
	logic [7:0]          code_q;
	logic                load_q;
	logic [AW-1:0]       best_q;
	logic [AgeWidth-1:0] oldest_q;

	// Output registers
	logic                o_at_end_q;
	logic [2:0]          o_used_q;
	logic [20:0]         o_point_q;
	logic [7:0]          o_code_q;
	logic                o_load_q;
	logic [SylWidth-1:0] o_fidx_q;

	// Combinational signals
	dec_t                dec;
	logic                dec_hangul;
	logic [7:0]          dec_code;
	logic                in_acc;
	logic                out_free;
	logic                more;
	logic                hit_now;
	logic                miss_now;
	logic                ram_we;
	logic [AW-1:0]       ram_wr_addr;
	logic [AW-1:0]       victim;
	entry_t              ram_rd;
	entry_t              ram_wr;
	logic [EntryWidth-1:0] ram_rd_data;

	// Cache entry memory: syllable and age stamp per slot
	u8lru_ram #(
		.WIDTH (EntryWidth),
		.DEPTH (SLOT_COUNT)
	) u_slots (
		.clk     (clk),
		.we      (ram_we),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr),
		.rd_addr (idx_q[AW-1:0]),
		.rd_data (ram_rd_data)
	);

	assign ram_rd = entry_t'(ram_rd_data);

	// Decode one UTF-8 character from the input window
	always_comb begin
		dec.at_end = 1'b0;
		dec.used   = 3'd1;
		dec.point  = {13'd0, byte_first};
		if (byte_first == 8'h00) begin
			dec.at_end = 1'b1;
			dec.used   = 3'd0;
			dec.point  = '0;
		end else if (byte_first[7:5] == 3'b110 && byte_second[7:6] == 2'b10
				&& {byte_first[4:0], byte_second[5:0]} >= 11'h080) begin
			dec.used  = 3'd2;
			dec.point = {10'd0, byte_first[4:0], byte_second[5:0]};
		end else if (byte_first[7:4] == 4'b1110 && byte_second[7:6] == 2'b10
				&& byte_third[7:6] == 2'b10
				&& {byte_first[3:0], byte_second[5:0], byte_third[5:0]} >= 16'h0800) begin
			dec.used  = 3'd3;
			dec.point = {5'd0, byte_first[3:0], byte_second[5:0], byte_third[5:0]};
		end else if (byte_first[7:3] == 5'b11110 && byte_second[7:6] == 2'b10
				&& byte_third[7:6] == 2'b10 && byte_fourth[7:6] == 2'b10
				&& {byte_first[2:0], byte_second[5:0], byte_third[5:0],
					byte_fourth[5:0]} >= 21'h010000
				&& {byte_first[2:0], byte_second[5:0], byte_third[5:0],
					byte_fourth[5:0]} <= 21'h10FFFF) begin
			dec.used  = 3'd4;
			dec.point = {byte_first[2:0], byte_second[5:0], byte_third[5:0],
				byte_fourth[5:0]};
		end
	end

	// Classify the code point
	always_comb begin
		dec_hangul = dec.point inside {[HangulFirst:HangulLast]};
		dec_code   = (dec.point < 21'd256) ? dec.point[7:0] : CharUnknown;
	end

	// Scan decisions: hit on returned entry, miss once all filled slots are seen
	always_comb begin
		more     = (idx_q < fill_q);
		hit_now  = (state_q == ST_SCAN) && pend_s1 && (ram_rd.syl == syl_q);
		miss_now = (state_q == ST_SCAN) && !pend_s1 && !more;
		victim   = (fill_q < FullCount) ? fill_q[AW-1:0] : best_q;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = dec_hangul ? ST_SCAN : ST_FINISH;
				end
			end
			ST_SCAN: begin
				if (hit_now || miss_now) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State machine outputs
	always_comb begin
		in_stall    = 1'b1;
		ram_we      = 1'b0;
		ram_wr_addr = victim;
		ram_wr.syl  = syl_q;
		ram_wr.age  = age_q;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
			end
			ST_SCAN: begin
				ram_we      = hit_now || miss_now;
				ram_wr_addr = hit_now ? idx_s1 : victim;
			end
			ST_FINISH: begin
				in_stall = 1'b1;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			age_q       <= AgeWidth'(1);
			idx_q       <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// advance the age stamp on every cache write (hit or miss)
			if (ram_we) begin
				age_q <= age_q + AgeWidth'(1);
			end
			if (miss_now && fill_q < FullCount) begin
				fill_q <= fill_q + CW'(1);
			end
			// restart the scan on a new request, advance while reading
			if (in_acc) begin
				idx_q   <= '0;
				pend_s1 <= 1'b0;
			end else if (state_q == ST_SCAN) begin
				pend_s1 <= more && !hit_now;
				if (more && !hit_now) begin
					idx_q <= idx_q + CW'(1);
				end
			end
			// hand the result to the output register
			if (state_q == ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Request, scan and result payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			at_end_q <= dec.at_end;
			used_q   <= dec.used;
			point_q  <= dec.point;
			syl_q    <= SylWidth'(dec.point - HangulFirst);
			code_q   <= dec_code;
			load_q   <= 1'b0;
			best_q   <= '0;
			oldest_q <= '1;
		end else if (state_q == ST_SCAN) begin
			idx_s1 <= idx_q[AW-1:0];
			// track the oldest entry, lowest index on a tie
			if (pend_s1 && !hit_now && ram_rd.age < oldest_q) begin
				oldest_q <= ram_rd.age;
				best_q   <= idx_s1;
			end
			if (hit_now) begin
				code_q <= SlotBase + 8'(idx_s1);
			end else if (miss_now) begin
				code_q <= SlotBase + 8'(victim);
				load_q <= 1'b1;
			end
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && out_free) begin
			o_at_end_q <= at_end_q;
			o_used_q   <= used_q;
			o_point_q  <= point_q;
			o_code_q   <= code_q;
			o_load_q   <= load_q;
			o_fidx_q   <= load_q ? syl_q : '0;
		end
	end

	assign out_valid     = out_valid_q;
	assign at_end        = o_at_end_q;
	assign bytes_used    = o_used_q;
	assign decoded_point = o_point_q;
	assign char_code     = o_code_q;
	assign load_glyph    = o_load_q;
	assign font_index    = o_fidx_q;

	// Assertions
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FullCount)
		else $error("fill count beyond slot count");

	a_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_SCAN) && (ram_wr_addr < AW'(SLOT_COUNT) ||
			ram_wr_addr == AW'(SLOT_COUNT)) && (ram_wr_addr <= fill_q[AW-1:0] ||
			fill_q == FullCount))
		else $error("cache write outside scan or past fill point");

	a_age_step: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> age_q == $past(age_q) + AgeWidth'(1))
		else $error("age stamp did not advance on cache write");

	a_age_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!ram_we |=> $stable(age_q))
		else $error("age stamp changed without cache write");

	a_load_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && load_glyph |-> char_code >= SlotBase)
		else $error("glyph load without slot code");

	a_end_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && at_end |-> bytes_used == 3'd0 && decoded_point == '0 &&
			char_code == '0 && !load_glyph)
		else $error("end of text result carries data");

endmodule
`default_nettype wire
